// ===== src/cbrp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cbrp_pkg: shared types and constants for the bitmap row packer
// Image geometry, counter widths and the operation word that the front end
// hands to the packing back end.
// ----------------------------------------------------------------------------
package cbrp_pkg;

	localparam int ROW_WIDTH = 32;  // pixel characters per row (8..32)
	localparam int ROWS      = 32;  // rows per image (1..64)
	localparam int TAG_BYTES = 3;   // tag bytes per image (2..3)

	localparam int COL_W  = 6;
	localparam int ROW_W  = 7;
	localparam int TAG_W  = 2;
	localparam int BIT_W  = 5;      // bit index inside the row word
	localparam int WORD_W = 32;
	localparam int BYTE_W = 8;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = 2;
	localparam int FIFO_CW    = 3;

	typedef enum logic [1:0] {
		OP_PIXEL = 2'd0,  // write one bit of the row word
		OP_ROW   = 2'd1,  // send the row word, then clear it
		OP_TAG   = 2'd2   // keep and/or send the tag byte
	} op_kind_t;

	typedef struct packed {
		op_kind_t          kind;
		logic [BIT_W-1:0]  bit_idx;  // row word bit for OP_PIXEL
		logic [BYTE_W-1:0] data;     // input byte
		logic              keep;     // OP_TAG: store data as the image tag
		logic              emit;     // OP_TAG: send the tag word
	} op_t;

	// Column to row word bit: bit order flipped inside each byte.
	function automatic logic [BIT_W-1:0] bit_place(input logic [BIT_W-1:0] col);
		return {col[BIT_W-1:3], ~col[2:0]};
	endfunction

endpackage : cbrp_pkg
`default_nettype wire

// ===== src/cbrp_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cbrp_front: byte classifier
// Tracks column, row and tag position and turns each byte into an operation
// for the back end. Tag bytes that carry no information are dropped here.
// ----------------------------------------------------------------------------
module cbrp_front
	import cbrp_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [BYTE_W-1:0] in_byte,
	output logic                   push,
	output op_t                    push_op,
	input  wire logic              q_full
);

	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [TAG_W-1:0] tag_q;

	logic accept, in_rows, in_pixels, tag_keep, tag_last;

	assign in_ready  = !q_full;
	assign accept    = in_valid && in_ready;
	assign in_rows   = row_q < ROW_W'(ROWS);
	assign in_pixels = col_q < COL_W'(ROW_WIDTH);
	assign tag_keep  = tag_q == TAG_W'(1);
	assign tag_last  = tag_q == TAG_W'(TAG_BYTES - 1);

	always_comb begin
		push_op.bit_idx = bit_place(col_q[BIT_W-1:0]);
		push_op.data    = in_byte;
		push_op.keep    = 1'b0;
		push_op.emit    = 1'b0;
		push_op.kind    = OP_PIXEL;
		push            = 1'b0;
		priority if (in_rows && in_pixels) begin
			push = accept;
		end else if (in_rows) begin
			push_op.kind = OP_ROW;
			push         = accept;
		end else begin
			push_op.kind = OP_TAG;
			push_op.keep = tag_keep;
			push_op.emit = tag_last;
			push         = accept && (tag_keep || tag_last);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			tag_q <= '0;
		end else if (accept) begin
			priority if (in_rows && in_pixels) begin
				col_q <= col_q + COL_W'(1);
			end else if (in_rows) begin
				col_q <= '0;
				row_q <= row_q + ROW_W'(1);
			end else if (tag_last) begin
				tag_q <= '0;
				row_q <= '0;
				col_q <= '0;
			end else begin
				tag_q <= tag_q + TAG_W'(1);
			end
		end
	end

endmodule : cbrp_front
`default_nettype wire

// ===== src/cbrp_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cbrp_fifo: operation queue
// Small FIFO between classifier and packer; push and pop in the same cycle.
// ----------------------------------------------------------------------------
module cbrp_fifo
	import cbrp_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire op_t  push_op,
	output logic      full,
	input  wire logic pop,
	output op_t       head,
	output logic      empty
);

	op_t                mem [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_q, rd_q;
	logic [FIFO_CW-1:0] cnt_q;

	assign full  = cnt_q == FIFO_CW'(FIFO_DEPTH);
	assign empty = cnt_q == '0;
	assign head  = mem[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + FIFO_AW'(1);
			end
			if (pop) begin
				rd_q <= rd_q + FIFO_AW'(1);
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + FIFO_CW'(1);
				2'b01:   cnt_q <= cnt_q - FIFO_CW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push) else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !pop) else $error("pop from empty queue");
`endif

endmodule : cbrp_fifo
`default_nettype wire

// ===== src/cbrp_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cbrp_back: row packer
// Executes queued operations: builds the row word bit by bit, keeps the tag
// byte and loads finished words into the output register.
// ----------------------------------------------------------------------------
module cbrp_back
	import cbrp_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire op_t               head,
	input  wire logic              empty,
	output logic                   pop,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [WORD_W-1:0]      out_word,
	output logic                   out_tag
);

	logic [WORD_W-1:0] row_bits_q;
	logic [BYTE_W-1:0] kept_tag_q;
	logic              out_valid_q;
	logic [WORD_W-1:0] out_word_q;
	logic              out_tag_q;

	logic              out_free, sends;
	logic [BYTE_W-1:0] tag_val;

	assign out_free = !out_valid_q || out_ready;
	assign sends    = (head.kind == OP_ROW) || (head.kind == OP_TAG && head.emit);
	assign pop      = !empty && (!sends || out_free);
	assign tag_val  = head.keep ? head.data : kept_tag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_bits_q  <= '0;
			kept_tag_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// a new word only loads when the register is free
			if (pop && sends) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (pop) begin
				unique case (head.kind)
					OP_PIXEL: row_bits_q[head.bit_idx] <= head.data[0];
					OP_ROW: begin
						row_bits_q <= '0;
					end
					OP_TAG: begin
						if (head.keep) begin
							kept_tag_q <= head.data;
						end
						if (head.emit) begin
							row_bits_q <= '0;
						end
					end
					default: row_bits_q <= row_bits_q;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && sends) begin
			out_tag_q  <= head.kind == OP_TAG;
			out_word_q <= (head.kind == OP_TAG) ?
				{{(WORD_W-BYTE_W){1'b0}}, tag_val} : row_bits_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;
	assign out_tag   = out_tag_q;

endmodule : cbrp_back
`default_nettype wire

// ===== src/char_bitmap_row_packer_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// char_bitmap_row_packer_unit: text bitmap to row word packer
// Packs bit 0 of pixel characters into 32-bit row words and closes every
// image with a tag word that carries the second tag byte.
// ----------------------------------------------------------------------------
//
// channel  dir  tdata                  tuser          tlast
// s_axis   in   [7:0] char_byte        -              -
// m_axis   out  [31:0] packed_word     [0] is_tag     last_of_image
//
// Flow: one byte per cycle while s_tready is high; a row word or tag word
//   enters the output register when the packer pops the byte that ends it.
// Reset: arst_n clears counters, queue pointers, row word and output valid.
// Stalls: the 4-entry operation queue fills only while m_tready is low;
//   s_tready then drops. Pixel and dropped tag bytes never wait on m_tready
//   directly; the output register is refilled in the cycle it is taken.
//
module char_bitmap_row_packer_unit
	import cbrp_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [7:0]        s_tdata,   // [7:0] char_byte
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [WORD_W-1:0]      m_tdata,   // [31:0] packed_word
	output logic                   m_tuser,   // [0] is_tag
	output logic                   m_tlast    // last_of_image
);

	// classifier -> queue
	logic push, q_full, q_empty, pop;
	op_t  push_op, head;

	cbrp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_byte  (s_tdata),
		.push     (push),
		.push_op  (push_op),
		.q_full   (q_full)
	);

	cbrp_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.full    (q_full),
		.pop     (pop),
		.head    (head),
		.empty   (q_empty)
	);

	// packer with output register; tag word is always the image's last
	logic out_tag;

	cbrp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (q_empty),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_word  (m_tdata),
		.out_tag   (out_tag)
	);

	assign m_tuser = out_tag;
	assign m_tlast = out_tag;

`ifndef ASSERT_OFF
	a_tag_word_high_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata[WORD_W-1:BYTE_W] == '0))
		else $error("tag word has bits above the tag byte");
	a_queue_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !s_tready)
		else $error("input open while queue is full");
	a_row_bits_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> ((m_tdata >> ROW_WIDTH) == '0))
		else $error("row word has bits beyond the row width");
`endif

endmodule : char_bitmap_row_packer_unit
`default_nettype wire
